FILE: rtl/mgd_pkg.sv
// ----------------------------------------------------------------------------
// mgd_pkg
// Shared types and constants for the mouse gesture direction detector.
// ----------------------------------------------------------------------------
package mgd_pkg;

    // event kinds carried on the input stream
    typedef enum logic [1:0] {
        CMD_DOWN = 2'd0,
        CMD_UP   = 2'd1,
        CMD_MOVE = 2'd2,
        CMD_TICK = 2'd3
    } t_cmd;

    // gesture directions, y grows downward
    typedef enum logic [2:0] {
        DIR_U  = 3'd0,
        DIR_UR = 3'd1,
        DIR_R  = 3'd2,
        DIR_DR = 3'd3,
        DIR_D  = 3'd4,
        DIR_DL = 3'd5,
        DIR_L  = 3'd6,
        DIR_UL = 3'd7
    } t_dir;

    // configuration register indexes
    localparam logic [1:0] CFG_MOVE_DIST  = 2'd0;
    localparam logic [1:0] CFG_JUDGE_DIST = 2'd1;
    localparam logic [1:0] CFG_INT_TICKS  = 2'd2;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int DIST_BITS     = 15;
    localparam int DIST_SQ_BITS  = 2 * DIST_BITS;
    localparam int TICK_BITS     = 16;

    // reset values
    localparam int MOVE_DIST_RST = 30;
    localparam logic [DIST_SQ_BITS-1:0] MOVE_DIST_SQ_RST =
        DIST_SQ_BITS'(MOVE_DIST_RST * MOVE_DIST_RST);
    localparam logic [DIST_BITS-1:0] JUDGE_DIST_RST = DIST_BITS'(10);
    localparam logic [TICK_BITS-1:0] INT_TICKS_RST  = TICK_BITS'(300);

    // active configuration, radius held already squared
    typedef struct packed {
        logic [DIST_SQ_BITS-1:0] move_dist_sq;
        logic [DIST_BITS-1:0]    judge_dist;
        logic [TICK_BITS-1:0]    int_ticks;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic replay_click;
        t_dir gesture_dir;
        logic gesture_valid;
        logic consumed;
    } t_res;

endpackage

FILE: rtl/mgd_cfg.sv
// ----------------------------------------------------------------------------
// mgd_cfg
// Configuration registers; the move radius is squared as it is written.
// ----------------------------------------------------------------------------
module mgd_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mgd_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mgd_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output mgd_pkg::t_cfg                      o_cfg
);

    logic [mgd_pkg::DIST_BITS-1:0]    w_dist;
    logic [mgd_pkg::DIST_SQ_BITS-1:0] w_dist_sq;
    mgd_pkg::t_cfg                    r_cfg;

    // square of the written radius
    assign w_dist    = i_cfg_wdata[mgd_pkg::DIST_BITS-1:0];
    assign w_dist_sq = mgd_pkg::DIST_SQ_BITS'(w_dist) * mgd_pkg::DIST_SQ_BITS'(w_dist);

    // register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_dist_sq <= mgd_pkg::MOVE_DIST_SQ_RST;
            r_cfg.judge_dist   <= mgd_pkg::JUDGE_DIST_RST;
            r_cfg.int_ticks    <= mgd_pkg::INT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mgd_pkg::CFG_MOVE_DIST:  r_cfg.move_dist_sq <= w_dist_sq;
                mgd_pkg::CFG_JUDGE_DIST: r_cfg.judge_dist   <= w_dist;
                mgd_pkg::CFG_INT_TICKS:  r_cfg.int_ticks    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/mgd_eval.sv
// ----------------------------------------------------------------------------
// mgd_eval
// Gesture window state and the per-event decision logic.
// ----------------------------------------------------------------------------
module mgd_eval #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  mgd_pkg::t_cmd                i_cmd,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  mgd_pkg::t_cfg                i_cfg,
    output mgd_pkg::t_res                o_res
);

    localparam int DW = COORD_BITS + 1;
    localparam int MW = (DW > 16) ? DW : 16;
    localparam int CW = (DW + 1 > 17) ? DW + 1 : 17;
    localparam int SQ = mgd_pkg::DIST_SQ_BITS;

    logic signed [COORD_BITS-1:0]     r_origin_x;
    logic signed [COORD_BITS-1:0]     r_origin_y;
    logic [mgd_pkg::TICK_BITS-1:0]    r_ticks_left;
    logic                             r_click_replaced;
    logic signed [COORD_BITS-1:0]     n_origin_x;
    logic signed [COORD_BITS-1:0]     n_origin_y;
    logic [mgd_pkg::TICK_BITS-1:0]    n_ticks_left;
    logic                             n_click_replaced;

    logic                             w_open;
    logic signed [DW-1:0]             w_dx;
    logic signed [DW-1:0]             w_dy;
    logic [DW-1:0]                    w_mag_x;
    logic [DW-1:0]                    w_mag_y;
    logic [MW-1:0]                    w_mag_xw;
    logic [MW-1:0]                    w_mag_yw;
    logic [mgd_pkg::DIST_BITS-1:0]    w_lo_x;
    logic [mgd_pkg::DIST_BITS-1:0]    w_lo_y;
    logic [SQ-1:0]                    w_sq_x;
    logic [SQ-1:0]                    w_sq_y;
    logic [SQ:0]                      w_sum;
    logic                             w_far;
    logic signed [CW-1:0]             w_dxc;
    logic signed [CW-1:0]             w_dyc;
    logic signed [CW-1:0]             w_jp;
    logic signed [CW-1:0]             w_jn;
    mgd_pkg::t_dir                    w_dir;
    mgd_pkg::t_res                    w_res;

    assign w_open = (r_ticks_left != '0);

    // displacement from the origin and its magnitude
    assign w_dx      = DW'(i_pos_x) - DW'(r_origin_x);
    assign w_dy      = DW'(i_pos_y) - DW'(r_origin_y);
    assign w_mag_x   = w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
    assign w_mag_y   = w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
    assign w_mag_xw  = MW'(w_mag_x);
    assign w_mag_yw  = MW'(w_mag_y);
    assign w_lo_x    = w_mag_xw[mgd_pkg::DIST_BITS-1:0];
    assign w_lo_y    = w_mag_yw[mgd_pkg::DIST_BITS-1:0];

    // distance test, any axis beyond the radius range passes at once
    assign w_sq_x = SQ'(w_lo_x) * SQ'(w_lo_x);
    assign w_sq_y = SQ'(w_lo_y) * SQ'(w_lo_y);
    assign w_sum  = (SQ+1)'(w_sq_x) + (SQ+1)'(w_sq_y);
    assign w_far  = (|w_mag_xw[MW-1:mgd_pkg::DIST_BITS])
                  | (|w_mag_yw[MW-1:mgd_pkg::DIST_BITS])
                  | (w_sum >= (SQ+1)'(i_cfg.move_dist_sq));

    // direction with a dead band on each axis
    assign w_dxc = CW'(w_dx);
    assign w_dyc = CW'(w_dy);
    assign w_jp  = CW'($signed({1'b0, i_cfg.judge_dist}));
    assign w_jn  = -w_jp;

    always_comb begin
        if (w_dyc < w_jn) begin
            if (w_dxc < w_jn)      w_dir = mgd_pkg::DIR_UL;
            else if (w_dxc > w_jp) w_dir = mgd_pkg::DIR_UR;
            else                   w_dir = mgd_pkg::DIR_U;
        end else if (w_dyc > w_jp) begin
            if (w_dxc < w_jn)      w_dir = mgd_pkg::DIR_DL;
            else if (w_dxc > w_jp) w_dir = mgd_pkg::DIR_DR;
            else                   w_dir = mgd_pkg::DIR_D;
        end else if (w_dxc < w_jn) begin
            w_dir = mgd_pkg::DIR_L;
        end else begin
            w_dir = mgd_pkg::DIR_R;
        end
    end

    // event decode, result and next window state
    always_comb begin
        n_origin_x       = r_origin_x;
        n_origin_y       = r_origin_y;
        n_ticks_left     = r_ticks_left;
        n_click_replaced = r_click_replaced;
        w_res            = '0;
        unique case (i_cmd)
            mgd_pkg::CMD_DOWN: begin
                w_res.consumed = 1'b1;
                if (!w_open) begin
                    n_origin_x   = i_pos_x;
                    n_origin_y   = i_pos_y;
                    n_ticks_left = i_cfg.int_ticks;
                end
            end
            mgd_pkg::CMD_UP: begin
                w_res.consumed = 1'b1;
                if (r_click_replaced) begin
                    n_click_replaced = 1'b0;
                end else begin
                    n_ticks_left       = '0;
                    w_res.replay_click = 1'b1;
                end
            end
            mgd_pkg::CMD_MOVE: begin
                if (w_open && w_far) begin
                    w_res.gesture_valid = 1'b1;
                    w_res.gesture_dir   = w_dir;
                    n_click_replaced    = 1'b1;
                    n_ticks_left        = '0;
                end
            end
            mgd_pkg::CMD_TICK: begin
                if (w_open) begin
                    n_ticks_left = r_ticks_left - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // window state, updated as each request leaves for the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x       <= '0;
            r_origin_y       <= '0;
            r_ticks_left     <= '0;
            r_click_replaced <= 1'b0;
        end else if (i_fire) begin
            r_origin_x       <= n_origin_x;
            r_origin_y       <= n_origin_y;
            r_ticks_left     <= n_ticks_left;
            r_click_replaced <= n_click_replaced;
        end
    end

    assign o_res = w_res;

    // a decided gesture closes the window and marks the click replaced
    a_gesture_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_res.gesture_valid |=> (r_ticks_left == '0) && r_click_replaced)
        else $error("window still open after a gesture");

    // gestures only come from move requests with the window open
    a_gesture_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.gesture_valid |-> (i_cmd == mgd_pkg::CMD_MOVE) && w_open)
        else $error("gesture outside a move in an open window");

    // a tick in an open window counts down by one
    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_cmd == mgd_pkg::CMD_TICK) && w_open
        |=> r_ticks_left == $past(r_ticks_left) - 1'b1)
        else $error("tick did not count the window down");

    // button requests are always swallowed, others never
    a_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> w_res.consumed ==
            ((i_cmd == mgd_pkg::CMD_DOWN) || (i_cmd == mgd_pkg::CMD_UP)))
        else $error("consumed flag disagrees with the event kind");

endmodule

FILE: rtl/mouse_gesture_direction_detector.sv
// ----------------------------------------------------------------------------
// mouse_gesture_direction_detector
// Turns right-button, move and tick events into eight-way gesture reports.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input register, then the result register.
// Throughput: one event per cycle unless m_tready stalls; the window state in
// mgd_eval updates as a request moves from the input to the result register.
// Reset: synchronous, active low; clears the window state, both valid flags
// and loads the register defaults (radius 30, dead band 10, window 300 ticks).
module mouse_gesture_direction_detector #(
    parameter int COORD_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // slave side
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // s_tdata: pos_x, pos_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    // s_tuser: cmd
    input  logic [1:0]                                  s_tuser,
    // master side
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // m_tdata: consumed, gesture_valid, gesture_dir[2:0], replay_click, zero pad
    output logic [7:0]                                  m_tdata,
    // configuration write port
    input  logic                                        i_cfg_we,
    input  logic [mgd_pkg::CFG_IDX_BITS-1:0]            i_cfg_idx,
    input  logic [mgd_pkg::CFG_DATA_BITS-1:0]           i_cfg_wdata
);

    logic                         r_in_valid;
    mgd_pkg::t_cmd                r_cmd;
    logic signed [COORD_BITS-1:0] r_pos_x;
    logic signed [COORD_BITS-1:0] r_pos_y;
    logic                         r_out_valid;
    mgd_pkg::t_res                r_res;

    logic                         w_adv;
    logic                         w_fire;
    mgd_pkg::t_cfg                w_cfg;
    mgd_pkg::t_res                w_res;

    // handshake: the input register refills whenever its request moves on
    assign w_adv    = !r_out_valid || m_tready;
    assign w_fire   = r_in_valid && w_adv;
    assign s_tready = !r_in_valid || w_adv;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_cmd   <= mgd_pkg::t_cmd'(s_tuser);
            r_pos_x <= s_tdata[COORD_BITS-1:0];
            r_pos_y <= s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    mgd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    mgd_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_cmd   (r_cmd),
        .i_pos_x (r_pos_x),
        .i_pos_y (r_pos_y),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_res.replay_click, r_res.gesture_dir,
                       r_res.gesture_valid, r_res.consumed};

endmodule
